### hdl/mnt_pkg.sv
// Shared types, sizes and codes of the mesh neighbour table.
package mnt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int EVICT_CUT   = TABLE_DEPTH / 4;
    localparam int OUT_CNT_W   = 6;
    localparam int ADDR_W      = 24;
    localparam int TIME_W      = 32;
    localparam int RADIO_W     = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_DROP_NONE = 2'd0;
    localparam logic [1:0] ST_DROP_OWN  = 2'd1;
    localparam logic [1:0] ST_UPDATED   = 2'd2;
    localparam logic [1:0] ST_INSERTED  = 2'd3;

    localparam logic CFG_OWN_ADDRESS = 1'b0;
    localparam logic CFG_TIMEOUT     = 1'b1;

    localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd300000;

    typedef struct packed {
        logic [ADDR_W-1:0]  src;
        logic [TIME_W-1:0]  now;
        logic [RADIO_W-1:0] rssi;
        logic [RADIO_W-1:0] snr;
        logic               has_dst;
        logic [ADDR_W-1:0]  dst;
        logic               drop_none;
        logic               drop_own;
        logic               dst_us;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [TIME_W-1:0]  last_seen;
        logic [RADIO_W-1:0] rssi;
        logic [RADIO_W-1:0] snr;
    } entry_t;

endpackage

### hdl/mnt_fifo.sv
// Short queue between the front classifier and the table sequencer.
module mnt_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  mnt_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output mnt_pkg::item_t pop_item
);

    mnt_pkg::item_t                   slot_reg [mnt_pkg::QUEUE_DEPTH];
    logic [mnt_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [mnt_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [mnt_pkg::QCNT_W-1:0]       fill_reg;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = (fill_reg != mnt_pkg::QCNT_W'(mnt_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

### hdl/mnt_front.sv
// Front end: take input beats, classify drops and destination, hand on to the queue.
module mnt_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [95:0]                   s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic [mnt_pkg::ADDR_W-1:0]    own_address,
    output logic                          push_valid,
    input  logic                          push_ready,
    output mnt_pkg::item_t                push_item
);

    logic           stage_valid_reg;
    mnt_pkg::item_t stage_reg;
    mnt_pkg::item_t item_c;

    assign s_tready   = !stage_valid_reg || push_ready;
    assign push_valid = stage_valid_reg;
    assign push_item  = stage_reg;

    always_comb
    begin
        item_c.src       = s_tdata[23:0];
        item_c.now       = s_tdata[55:24];
        item_c.rssi      = s_tdata[63:56];
        item_c.snr       = s_tdata[71:64];
        item_c.dst       = s_tdata[95:72];
        item_c.has_dst   = s_tuser[0];
        item_c.drop_none = (s_tdata[23:0] == '0);
        item_c.drop_own  = (s_tdata[23:0] == own_address);
        item_c.dst_us    = (s_tdata[95:72] == own_address);
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            stage_reg <= item_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

endmodule

### hdl/mnt_back.sv
// Back end: table store, walk sequencer for lookup, expiry and eviction, result register.
module mnt_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  mnt_pkg::item_t                pop_item,
    input  logic [mnt_pkg::TIME_W-1:0]    timeout,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata
);

    localparam int IW = mnt_pkg::IDX_W;
    localparam int CW = mnt_pkg::CNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_EXP  = 3'd2;
    localparam logic [2:0] S_EVW  = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [$bits(mnt_pkg::entry_t)-1:0] mem [mnt_pkg::TABLE_DEPTH];
    logic [$bits(mnt_pkg::entry_t)-1:0] rd_data_reg;

    logic [2:0]                       state_reg;
    mnt_pkg::item_t                   item_reg;
    logic [mnt_pkg::TABLE_DEPTH-1:0]  valid_reg;
    logic [CW-1:0]                    count_reg;
    logic [IW:0]                      cnt_reg;
    logic                             pend_reg;
    logic [IW-1:0]                    pidx_reg;
    logic                             src_found_reg;
    logic [IW-1:0]                    src_slot_reg;
    logic                             free_found_reg;
    logic [IW-1:0]                    free_slot_reg;
    logic                             dst_found_reg;
    logic [IW-1:0]                    dst_slot_reg;
    logic                             min_found_reg;
    logic [IW-1:0]                    min_slot_reg;
    logic                             best_found_reg;
    logic [IW-1:0]                    best_slot_reg;
    logic [mnt_pkg::TIME_W-1:0]       best_age_reg;
    logic [CW-1:0]                    evict_reg;
    logic [CW-1:0]                    round_reg;
    logic                             ins_reg;
    logic [IW-1:0]                    slot_reg;
    logic [1:0]                       status_reg;
    logic                             is_us_reg;
    logic                             known_reg;
    logic                             m_valid_reg;
    logic [15:0]                      m_data_reg;

    mnt_pkg::entry_t                  rd_entry;
    mnt_pkg::entry_t                  wr_entry;
    logic [mnt_pkg::TIME_W-1:0]       age;
    logic                             slot_v;
    logic                             walk_last;
    logic                             walking;
    logic                             src_hit;
    logic                             free_hit;
    logic                             dst_hit;
    logic                             exp_hit;
    logic                             best_take;
    logic [IW-1:0]                    src_slot_c;
    logic [IW-1:0]                    free_slot_c;
    logic [IW-1:0]                    min_slot_c;
    logic [IW-1:0]                    best_slot_c;
    logic [IW-1:0]                    ev_min_c;
    logic [CW-1:0]                    evict_c;
    logic                             out_free;

    assign pop_ready = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_free  = !m_valid_reg || m_tready;

    always_comb
    begin
        rd_entry    = mnt_pkg::entry_t'(rd_data_reg);
        age         = item_reg.now - rd_entry.last_seen;
        slot_v      = valid_reg[pidx_reg];
        walk_last   = pend_reg && (pidx_reg == IW'(mnt_pkg::TABLE_DEPTH - 1));
        walking     = (state_reg == S_SRCH) || (state_reg == S_EXP) || (state_reg == S_EVW);
        src_hit     = pend_reg && slot_v && (rd_entry.addr == item_reg.src);
        free_hit    = pend_reg && !slot_v;
        dst_hit     = pend_reg && slot_v && (rd_entry.addr == item_reg.dst);
        exp_hit     = pend_reg && slot_v && (age > timeout);
        best_take   = pend_reg && slot_v && (!best_found_reg || (age > best_age_reg));
        src_slot_c  = src_found_reg ? src_slot_reg : pidx_reg;
        free_slot_c = free_found_reg ? free_slot_reg : pidx_reg;
        min_slot_c  = min_found_reg ? min_slot_reg : pidx_reg;
        best_slot_c = best_take ? pidx_reg : best_slot_reg;
        ev_min_c    = (min_found_reg && (min_slot_reg < best_slot_c)) ? min_slot_reg
                                                                       : best_slot_c;
        evict_c     = evict_reg + CW'(exp_hit);
        wr_entry.addr      = item_reg.src;
        wr_entry.last_seen = item_reg.now;
        wr_entry.rssi      = item_reg.rssi;
        wr_entry.snr       = item_reg.snr;
    end

    // table store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WR)
        begin
            mem[slot_reg] <= wr_entry;
        end
        rd_data_reg <= mem[cnt_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && pop_valid)
        begin
            item_reg <= pop_item;
        end
    end

    // result register: load when the verdict is ready and the slot is free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end
        else if (state_reg == S_DONE && out_free)
        begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= {mnt_pkg::OUT_CNT_W'(count_reg),
                            mnt_pkg::OUT_CNT_W'(evict_reg),
                            known_reg, is_us_reg, status_reg};
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            count_reg      <= '0;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            pidx_reg       <= '0;
            src_found_reg  <= 1'b0;
            src_slot_reg   <= '0;
            free_found_reg <= 1'b0;
            free_slot_reg  <= '0;
            dst_found_reg  <= 1'b0;
            dst_slot_reg   <= '0;
            min_found_reg  <= 1'b0;
            min_slot_reg   <= '0;
            best_found_reg <= 1'b0;
            best_slot_reg  <= '0;
            best_age_reg   <= '0;
            evict_reg      <= '0;
            round_reg      <= '0;
            ins_reg        <= 1'b0;
            slot_reg       <= '0;
            status_reg     <= mnt_pkg::ST_DROP_NONE;
            is_us_reg      <= 1'b0;
            known_reg      <= 1'b0;
        end
        else
        begin
            // address issue for the slot walk; rewind at the end of each walk and when idle
            if (walk_last || (state_reg == S_IDLE))
            begin
                cnt_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (walking)
            begin
                if (cnt_reg < (IW+1)'(mnt_pkg::TABLE_DEPTH))
                begin
                    cnt_reg  <= cnt_reg + 1'b1;
                    pend_reg <= 1'b1;
                    pidx_reg <= cnt_reg[IW-1:0];
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop_valid)
                    begin
                        src_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        dst_found_reg  <= 1'b0;
                        min_found_reg  <= 1'b0;
                        best_found_reg <= 1'b0;
                        evict_reg      <= '0;
                        round_reg      <= '0;
                        known_reg      <= 1'b0;
                        is_us_reg      <= !pop_item.drop_none && !pop_item.drop_own
                                          && pop_item.has_dst && pop_item.dst_us;
                        if (pop_item.drop_none)
                        begin
                            status_reg <= mnt_pkg::ST_DROP_NONE;
                            state_reg  <= S_DONE;
                        end
                        else if (pop_item.drop_own)
                        begin
                            status_reg <= mnt_pkg::ST_DROP_OWN;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_SRCH;
                        end
                    end
                end
                S_SRCH:
                begin
                    if (src_hit && !src_found_reg)
                    begin
                        src_found_reg <= 1'b1;
                        src_slot_reg  <= pidx_reg;
                    end
                    if (free_hit && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_slot_reg  <= pidx_reg;
                    end
                    if (dst_hit)
                    begin
                        dst_found_reg <= 1'b1;
                        dst_slot_reg  <= pidx_reg;
                    end
                    if (walk_last)
                    begin
                        priority if (src_found_reg || src_hit)
                        begin
                            ins_reg   <= 1'b0;
                            slot_reg  <= src_slot_c;
                            state_reg <= S_WR;
                        end
                        else if (count_reg < CW'(mnt_pkg::TABLE_DEPTH))
                        begin
                            ins_reg   <= 1'b1;
                            slot_reg  <= free_slot_c;
                            state_reg <= S_WR;
                        end
                        else
                        begin
                            state_reg <= S_EXP;
                        end
                    end
                end
                S_EXP:
                begin
                    if (exp_hit)
                    begin
                        valid_reg[pidx_reg] <= 1'b0;
                        count_reg           <= count_reg - 1'b1;
                        evict_reg           <= evict_c;
                        if (!min_found_reg)
                        begin
                            min_found_reg <= 1'b1;
                            min_slot_reg  <= pidx_reg;
                        end
                    end
                    if (walk_last)
                    begin
                        if (evict_c != '0)
                        begin
                            ins_reg   <= 1'b1;
                            slot_reg  <= min_slot_c;
                            state_reg <= S_WR;
                        end
                        else
                        begin
                            state_reg <= S_EVW;
                        end
                    end
                end
                S_EVW:
                begin
                    if (best_take)
                    begin
                        best_found_reg <= 1'b1;
                        best_slot_reg  <= pidx_reg;
                        best_age_reg   <= age;
                    end
                    if (walk_last)
                    begin
                        // drop the oldest entry of this round
                        valid_reg[best_slot_c] <= 1'b0;
                        count_reg              <= count_reg - 1'b1;
                        evict_reg              <= evict_reg + 1'b1;
                        min_found_reg          <= 1'b1;
                        min_slot_reg           <= ev_min_c;
                        best_found_reg         <= 1'b0;
                        round_reg              <= round_reg + 1'b1;
                        if (round_reg == CW'(mnt_pkg::EVICT_CUT - 1))
                        begin
                            ins_reg   <= 1'b1;
                            slot_reg  <= ev_min_c;
                            state_reg <= S_WR;
                        end
                    end
                end
                S_WR:
                begin
                    status_reg <= ins_reg ? mnt_pkg::ST_INSERTED : mnt_pkg::ST_UPDATED;
                    if (ins_reg)
                    begin
                        valid_reg[slot_reg] <= 1'b1;
                        count_reg           <= count_reg + 1'b1;
                    end
                    known_reg <= item_reg.has_dst && !item_reg.dst_us
                                 && ((item_reg.dst == item_reg.src)
                                     || (dst_found_reg && valid_reg[dst_slot_reg]));
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### hdl/mesh_neighbor_table.sv
// Top level of the mesh neighbour table: configuration registers and the front/back split.
//
// Usage: one input beat per received frame header on the s_ group, one result beat per
// input beat on the m_ group, in order. Configuration (own address, neighbour timeout in
// ms) is written through cfg_we/cfg_index/cfg_data while the block is idle.
// The front stage takes a beat whenever its holding register is empty or moving on, flags
// zero-source and own-source frames and compares the destination with our address, then
// hands the frame through a two-entry queue to the back end.
// The back end walks the 32-slot table one slot a cycle through its single read port:
// a frame that is dropped goes straight to the result; an update or an insert into a table
// with room takes one lookup walk plus the write and the result.
// An insert into a full table adds an expiry walk and, if nothing expired, TABLE_DEPTH/4
// oldest-entry walks, each dropping the oldest entry left.
// Reset clears all valid bits, the occupancy count, the queue and the result register;
// the table payload store is not cleared and is only read behind a valid bit, so the block
// takes beats from the first cycle after reset. The own address resets to zero and the
// timeout to 300000 ms.
// When the receiver stalls, the result is held in the output register, the back end
// waits with the next result and the queue and front stage keep absorbing beats until full.
module mesh_neighbor_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // source_address, now_ms, rssi_dbm, snr_quarter_db,
                                   // destination_address
    input  logic [0:0]  s_tuser,   // has_destination
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status, destination_is_us, destination_known,
                                   // evicted_count, occupancy
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [mnt_pkg::ADDR_W-1:0] own_reg;
    logic [mnt_pkg::TIME_W-1:0] timeout_reg;

    logic           push_valid;
    logic           push_ready;
    mnt_pkg::item_t push_item;
    logic           pop_valid;
    logic           pop_ready;
    mnt_pkg::item_t pop_item;

    // configuration registers: write-only, taken on any cycle with cfg_we high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg     <= '0;
            timeout_reg <= mnt_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index[0])
                mnt_pkg::CFG_OWN_ADDRESS: own_reg     <= cfg_data[mnt_pkg::ADDR_W-1:0];
                mnt_pkg::CFG_TIMEOUT:     timeout_reg <= cfg_data;
                default:                  own_reg     <= own_reg;
            endcase
        end
    end

    // classify and hold one beat
    mnt_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .own_address (own_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    // decouple the front from the table walk
    mnt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // table walk, eviction and result beat
    mnt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .timeout   (timeout_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### hdl/mnt_checker.sv
// Port-level checks of the mesh neighbour table and their binding to the top level.
module mnt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [95:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled input beat holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("input beat changed under stall");

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed under stall");

    // occupancy never exceeds the table
    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:10] <= 6'(mnt_pkg::TABLE_DEPTH)))
        else $error("occupancy beyond table depth");

    // a dropped frame touches nothing
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == mnt_pkg::ST_DROP_NONE
                     || m_tdata[1:0] == mnt_pkg::ST_DROP_OWN)
        |-> (m_tdata[9:2] == '0))
        else $error("dropped frame reports evictions or destination");

    // an update never evicts, and the destination cannot be both us and a neighbour
    a_upd: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[2] && m_tdata[3])
                     && (m_tdata[1:0] != mnt_pkg::ST_UPDATED || m_tdata[9:4] == '0))
        else $error("inconsistent result flags");

endmodule

bind mesh_neighbor_table mnt_checker u_mnt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
